>>> hw/rtl/s3i_pkg.sv
// Shared types, constants and helper functions for the symmetric 3x3 inverse.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package s3i_pkg;

    localparam logic [31:0] V_ZERO = 32'h0000_0000;
    localparam logic [31:0] QNAN   = 32'h7FC0_0000;

    // Pipeline depths of the arithmetic units.
    localparam int LAT_NORM  = 2;
    localparam int LAT_MUL   = 1 + LAT_NORM;
    localparam int LAT_ADD   = 2 + LAT_NORM;
    localparam int DIV_STEPS = 27;
    localparam int LAT_RCP   = 1 + DIV_STEPS + LAT_NORM;

    // Alignment delays inside the top level.
    localparam int D_A     = LAT_MUL + LAT_ADD;
    localparam int D_M3    = LAT_ADD;
    localparam int D_COF   = LAT_MUL + 2 * LAT_ADD + LAT_RCP;
    localparam int D_SING  = LAT_RCP + LAT_MUL;
    localparam int LAT_ALL = 2 * LAT_MUL + 3 * LAT_ADD + LAT_RCP + LAT_MUL;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } t_fp_spec;

    typedef struct packed {
        logic        sign;
        logic [7:0]  exp;
        logic [23:0] mant;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
    } t_fp_unp;

    // Subnormals get exponent one and no hidden bit.
    function automatic t_fp_unp fp_unpack(input logic [31:0] w);
        t_fp_unp u;
        u.sign    = w[31];
        u.exp     = (w[30:23] == 8'd0) ? 8'd1 : w[30:23];
        u.mant    = {(w[30:23] != 8'd0), w[22:0]};
        u.is_nan  = (&w[30:23]) & (|w[22:0]);
        u.is_inf  = (&w[30:23]) & ~(|w[22:0]);
        u.is_zero = (w[30:0] == 31'd0);
        return u;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd0;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!hit) begin
                if (v[i]) begin
                    hit = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/symmetric_3x3_inverse.sv
// Symmetric 3x3 matrix inverse in IEEE single precision, fully pipelined.
// Uses s3i_pkg, s3i_fmul, s3i_fadd and s3i_frecip.
//
// Input channel: i_valid, o_stall and the six distinct entries i_a11 .. i_a33.
// A word is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall, the six inverse entries o_inv11 .. o_inv33
// and o_singular. A word is delivered at an edge with o_valid high and
// i_stall low.
// Throughput is one matrix per cycle while o_stall is low. The path from
// acceptance to o_valid: multiply, subtract, multiply, two adds, the
// 30-stage reciprocal (27 restoring division steps) and the final multiply.
// A zero determinant gives o_singular high and all entries +0; NaN entries
// come out as the quiet NaN 0x7FC00000.
// Reset (synchronous, active low) empties the pipeline and the output stage.
// When the receiver stalls, the output register holds its word and a skid
// register takes one more; only when both are full does the whole pipeline
// freeze and o_stall rise, so no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module symmetric_3x3_inverse
    import s3i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_a11,
    input  wire logic [31:0] i_a12,
    input  wire logic [31:0] i_a22,
    input  wire logic [31:0] i_a13,
    input  wire logic [31:0] i_a23,
    input  wire logic [31:0] i_a33,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_inv11,
    output logic      [31:0] o_inv12,
    output logic      [31:0] o_inv22,
    output logic      [31:0] o_inv13,
    output logic      [31:0] o_inv23,
    output logic      [31:0] o_inv33,
    output logic             o_singular
);

    logic en;
    logic in_acc;
    logic r_skid_vld;

    assign en      = ~r_skid_vld;
    assign o_stall = r_skid_vld;
    assign in_acc  = i_valid & en;

    // Cofactor products.
    logic [31:0] mul_l [6];
    logic [31:0] mul_r [6];
    logic [31:0] pl    [6];
    logic [31:0] pr    [6];
    logic [31:0] cof   [6];

    assign mul_l[0] = i_a22; assign mul_r[0] = i_a33;
    assign mul_l[1] = i_a13; assign mul_r[1] = i_a23;
    assign mul_l[2] = i_a11; assign mul_r[2] = i_a33;
    assign mul_l[3] = i_a12; assign mul_r[3] = i_a23;
    assign mul_l[4] = i_a13; assign mul_r[4] = i_a12;
    assign mul_l[5] = i_a11; assign mul_r[5] = i_a22;

    logic [31:0] sub_l [6];
    logic [31:0] sub_r [6];

    assign sub_l[0] = i_a23; assign sub_r[0] = i_a23;
    assign sub_l[1] = i_a12; assign sub_r[1] = i_a33;
    assign sub_l[2] = i_a13; assign sub_r[2] = i_a13;
    assign sub_l[3] = i_a13; assign sub_r[3] = i_a22;
    assign sub_l[4] = i_a11; assign sub_r[4] = i_a23;
    assign sub_l[5] = i_a12; assign sub_r[5] = i_a12;

    for (genvar k = 0; k < 6; k++) begin : g_cof
        s3i_fmul u_mul_l (
            .i_clk (i_clk), .i_en (en),
            .i_a (mul_l[k]), .i_b (mul_r[k]), .o_word (pl[k])
        );
        s3i_fmul u_mul_r (
            .i_clk (i_clk), .i_en (en),
            .i_a (sub_l[k]), .i_b (sub_r[k]), .o_word (pr[k])
        );
        s3i_fadd u_sub (
            .i_clk (i_clk), .i_en (en),
            .i_a (pl[k]), .i_b ({~pr[k][31], pr[k][30:0]}), .o_word (cof[k])
        );
    end

    // First row held until the cofactors are ready.
    logic [31:0] r_a_dly [D_A][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dly[0][0] <= i_a11;
            r_a_dly[0][1] <= i_a12;
            r_a_dly[0][2] <= i_a13;
            for (int i = 1; i < D_A; i++) begin
                r_a_dly[i] <= r_a_dly[i-1];
            end
        end
    end

    // Determinant: (a11*c11 + a12*c12) + a13*c13.
    logic [31:0] dm [3];
    logic [31:0] dsum;
    logic [31:0] det;
    logic [31:0] r_m3_dly [D_M3];

    s3i_fmul u_dm0 (
        .i_clk (i_clk), .i_en (en),
        .i_a (r_a_dly[D_A-1][0]), .i_b (cof[0]), .o_word (dm[0])
    );
    s3i_fmul u_dm1 (
        .i_clk (i_clk), .i_en (en),
        .i_a (r_a_dly[D_A-1][1]), .i_b (cof[1]), .o_word (dm[1])
    );
    s3i_fmul u_dm2 (
        .i_clk (i_clk), .i_en (en),
        .i_a (r_a_dly[D_A-1][2]), .i_b (cof[3]), .o_word (dm[2])
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_dly[0] <= dm[2];
            for (int i = 1; i < D_M3; i++) begin
                r_m3_dly[i] <= r_m3_dly[i-1];
            end
        end
    end

    s3i_fadd u_add0 (
        .i_clk (i_clk), .i_en (en),
        .i_a (dm[0]), .i_b (dm[1]), .o_word (dsum)
    );
    s3i_fadd u_add1 (
        .i_clk (i_clk), .i_en (en),
        .i_a (dsum), .i_b (r_m3_dly[D_M3-1]), .o_word (det)
    );

    logic [31:0] recip;

    s3i_frecip u_rcp (
        .i_clk (i_clk), .i_en (en), .i_d (det), .o_word (recip)
    );

    logic [D_SING-1:0] r_sing_dly;
    logic [31:0]       r_cof_dly [D_COF][6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing_dly <= {r_sing_dly[D_SING-2:0], (det[30:0] == 31'd0)};
            r_cof_dly[0] <= cof;
            for (int i = 1; i < D_COF; i++) begin
                r_cof_dly[i] <= r_cof_dly[i-1];
            end
        end
    end

    logic [31:0] inv [6];

    for (genvar k = 0; k < 6; k++) begin : g_out
        s3i_fmul u_mul_o (
            .i_clk (i_clk), .i_en (en),
            .i_a (r_cof_dly[D_COF-1][k]), .i_b (recip), .o_word (inv[k])
        );
    end

    // Valid bits follow the data through every stage.
    logic [LAT_ALL-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT_ALL-2:0], in_acc};
        end
    end

    logic        sing;
    logic [31:0] w [6];

    assign sing = r_sing_dly[D_SING-1];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w[k] = sing ? V_ZERO : inv[k];
        end
    end

    logic        push;
    logic        take;
    logic [31:0] r_skid [6];
    logic        r_skid_sing;

    assign push = r_vld[LAT_ALL-1] & en;
    assign take = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (o_valid && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                o_valid <= 1'b1;
            end
        end else if (take) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                o_inv11    <= r_skid[0];
                o_inv12    <= r_skid[1];
                o_inv22    <= r_skid[2];
                o_inv13    <= r_skid[3];
                o_inv23    <= r_skid[4];
                o_inv33    <= r_skid[5];
                o_singular <= r_skid_sing;
            end
        end else if (push) begin
            if (o_valid && !take) begin
                r_skid      <= w;
                r_skid_sing <= sing;
            end else begin
                o_inv11    <= w[0];
                o_inv12    <= w[1];
                o_inv22    <= w[2];
                o_inv13    <= w[3];
                o_inv23    <= w[4];
                o_inv33    <= w[5];
                o_singular <= sing;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> o_valid)
        else $error("skid register full while output register empty");

    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && i_stall |=> r_skid_vld && o_valid)
        else $error("buffered word dropped during stall");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_inv11 == V_ZERO) && (o_inv12 == V_ZERO)
            && (o_inv22 == V_ZERO) && (o_inv13 == V_ZERO)
            && (o_inv23 == V_ZERO) && (o_inv33 == V_ZERO))
        else $error("singular word carries nonzero entries");

    a_nan_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_inv11[30:23] == 8'hFF) && (o_inv11[22:0] != 23'd0)
            |-> o_inv11 == QNAN)
        else $error("NaN entry is not the canonical quiet NaN");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/s3i_norm.sv
// Normalize and round stage shared by the multiplier, adder and reciprocal.
// Two register stages; uses s3i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module s3i_norm
    import s3i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire t_fp_spec    i_spec,
    input  wire logic [47:0] i_p,
    input  wire logic [10:0] i_eb,
    output logic      [31:0] o_word
);

    // The value is i_p * 2^(eb - 173); a leading one at bit 46 means exponent eb.
    logic [5:0]         lz;
    logic signed [10:0] eb_s;
    logic signed [10:0] lz_s;
    logic signed [10:0] lsh;
    logic signed [10:0] base;

    t_fp_spec    r_spec;
    logic [47:0] r_p;
    logic [7:0]  r_lsh;
    logic [9:0]  r_base;

    always_comb begin
        lz   = lzc48(i_p);
        eb_s = $signed(i_eb);
        lz_s = $signed({5'd0, lz});
        lsh  = (eb_s < lz_s) ? eb_s : lz_s;
        base = eb_s - lsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= i_spec;
            r_p    <= i_p;
            r_lsh  <= lsh[7:0];
            r_base <= base[9:0];
        end
    end

    logic [7:0]  rs;
    logic [5:0]  rsc;
    logic [95:0] wide;
    logic [47:0] sh;
    logic        stx;
    logic [23:0] m;
    logic        inc;
    logic [32:0] total;
    logic [31:0] n_word;

    always_comb begin
        rs   = ~r_lsh + 8'd1;
        rsc  = (rs > 8'd48) ? 6'd48 : rs[5:0];
        wide = {r_p, 48'd0} >> rsc;
        if (r_lsh[7]) begin
            sh  = wide[95:48];
            stx = |wide[47:0];
        end else begin
            sh  = r_p << r_lsh[5:0];
            stx = 1'b0;
        end
        m     = sh[47:24];
        inc   = sh[23] & ((|sh[22:0]) | stx | m[0]);
        // A carry out of the mantissa moves into the exponent field.
        total = {r_base, 23'd0} + {9'd0, m} + {32'd0, inc};
        if (r_spec.nan) begin
            n_word = QNAN;
        end else if (r_spec.inf || (total[32:23] >= 10'd255)) begin
            n_word = {r_spec.sign, 8'hFF, 23'd0};
        end else if (r_spec.zero) begin
            n_word = {r_spec.sign, 31'd0};
        end else begin
            n_word = {r_spec.sign, total[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_word <= n_word;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/s3i_fmul.sv
// Pipelined single-precision multiplier: mantissa product, then s3i_norm.
// Uses s3i_pkg and s3i_norm.
`timescale 1ns / 1ps
`default_nettype none
module s3i_fmul
    import s3i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_word
);

    t_fp_unp     ua;
    t_fp_unp     ub;
    t_fp_spec    n_spec;
    logic [10:0] n_eb;

    t_fp_spec    r_spec;
    logic [47:0] r_p;
    logic [10:0] r_eb;

    always_comb begin
        ua          = fp_unpack(i_a);
        ub          = fp_unpack(i_b);
        n_spec.nan  = ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero)
                    | (ua.is_zero & ub.is_inf);
        n_spec.inf  = ua.is_inf | ub.is_inf;
        n_spec.zero = ua.is_zero | ub.is_zero;
        n_spec.sign = ua.sign ^ ub.sign;
        n_eb        = {3'd0, ua.exp} + {3'd0, ub.exp} - 11'd127;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= n_spec;
            r_p    <= {24'd0, ua.mant} * {24'd0, ub.mant};
            r_eb   <= n_eb;
        end
    end

    s3i_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_spec (r_spec),
        .i_p    (r_p),
        .i_eb   (r_eb),
        .o_word (o_word)
    );

endmodule
`default_nettype wire

>>> hw/rtl/s3i_fadd.sv
// Pipelined single-precision adder: align, add, then s3i_norm.
// Uses s3i_pkg and s3i_norm; subtraction is done by flipping the sign of i_b.
`timescale 1ns / 1ps
`default_nettype none
module s3i_fadd
    import s3i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [31:0] o_word
);

    t_fp_unp     ua;
    t_fp_unp     ub;
    t_fp_unp     big;
    t_fp_unp     sml;
    logic [7:0]  dexp;
    logic [4:0]  dc;
    logic [53:0] al;

    logic [26:0] r_big;
    logic [26:0] r_sml;
    logic        r_sub;
    logic        r_sign;
    logic        r_zsign;
    logic [7:0]  r_exp;
    logic        r_nan;
    logic        r_inf;
    logic        r_inf_sign;

    always_comb begin
        ua = fp_unpack(i_a);
        ub = fp_unpack(i_b);
        if (i_a[30:0] >= i_b[30:0]) begin
            big = ua;
            sml = ub;
        end else begin
            big = ub;
            sml = ua;
        end
        dexp = big.exp - sml.exp;
        dc   = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
        al   = {sml.mant, 3'd0, 27'd0} >> dc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_big      <= {big.mant, 3'd0};
            r_sml      <= al[53:27] | {26'd0, |al[26:0]};
            r_sub      <= ua.sign ^ ub.sign;
            r_sign     <= big.sign;
            r_zsign    <= ua.sign & ub.sign;
            r_exp      <= big.exp;
            r_nan      <= ua.is_nan | ub.is_nan
                        | (ua.is_inf & ub.is_inf & (ua.sign ^ ub.sign));
            r_inf      <= ua.is_inf | ub.is_inf;
            r_inf_sign <= ua.is_inf ? ua.sign : ub.sign;
        end
    end

    logic [27:0] sum;
    t_fp_spec    n_spec;
    t_fp_spec    r2_spec;
    logic [47:0] r2_p;
    logic [10:0] r2_eb;

    always_comb begin
        sum         = r_sub ? ({1'b0, r_big} - {1'b0, r_sml})
                            : ({1'b0, r_big} + {1'b0, r_sml});
        n_spec.nan  = r_nan;
        n_spec.inf  = r_inf;
        n_spec.zero = (sum == 28'd0);
        // An exact zero is negative only when both operands were negative.
        n_spec.sign = r_inf ? r_inf_sign : ((sum == 28'd0) ? r_zsign : r_sign);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_spec <= n_spec;
            r2_p    <= {sum, 20'd0};
            r2_eb   <= {3'd0, r_exp};
        end
    end

    s3i_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_spec (r2_spec),
        .i_p    (r2_p),
        .i_eb   (r2_eb),
        .o_word (o_word)
    );

endmodule
`default_nettype wire

>>> hw/rtl/s3i_frecip.sv
// Pipelined single-precision reciprocal: normalize, one quotient bit per
// stage by restoring division, then s3i_norm. Uses s3i_pkg and s3i_norm.
`timescale 1ns / 1ps
`default_nettype none
module s3i_frecip
    import s3i_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_d,
    output logic      [31:0] o_word
);

    localparam logic [24:0] REM_INIT = 25'h080_0000;

    t_fp_unp     ud;
    logic [5:0]  lz;
    t_fp_spec    n_spec;

    t_fp_spec    r_spec;
    logic [23:0] r_md;
    logic [10:0] r_eb;

    always_comb begin
        ud          = fp_unpack(i_d);
        lz          = lzc48({ud.mant, 24'd0});
        n_spec.nan  = ud.is_nan;
        n_spec.inf  = ud.is_zero;
        n_spec.zero = ud.is_inf;
        n_spec.sign = ud.sign;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= n_spec;
            r_md   <= ud.mant << lz;
            // 1/d = floor(2^49/md) scaled so that the norm exponent is 253 - ed + lz.
            r_eb   <= 11'd253 - {3'd0, ud.exp} + {5'd0, lz};
        end
    end

    logic [24:0] rin   [DIV_STEPS];
    logic [26:0] qin   [DIV_STEPS];
    logic [23:0] mdin  [DIV_STEPS];
    logic [10:0] ebin  [DIV_STEPS];
    t_fp_spec    spin  [DIV_STEPS];
    logic        ge    [DIV_STEPS];
    logic [24:0] rsub  [DIV_STEPS];

    logic [24:0] r_rem [DIV_STEPS];
    logic [26:0] r_q   [DIV_STEPS];
    logic [23:0] r_mdk [DIV_STEPS];
    logic [10:0] r_ebk [DIV_STEPS];
    t_fp_spec    r_spk [DIV_STEPS];

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rin[k]  = REM_INIT;
                qin[k]  = 27'd0;
                mdin[k] = r_md;
                ebin[k] = r_eb;
                spin[k] = r_spec;
            end else begin
                rin[k]  = r_rem[k-1];
                qin[k]  = r_q[k-1];
                mdin[k] = r_mdk[k-1];
                ebin[k] = r_ebk[k-1];
                spin[k] = r_spk[k-1];
            end
            ge[k]   = (rin[k] >= {1'b0, mdin[k]});
            rsub[k] = ge[k] ? (rin[k] - {1'b0, mdin[k]}) : rin[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= {rsub[k][23:0], 1'b0};
                r_q[k]   <= {qin[k][25:0], ge[k]};
                r_mdk[k] <= mdin[k];
                r_ebk[k] <= ebin[k];
                r_spk[k] <= spin[k];
            end
        end
    end

    logic [47:0] qv;

    // A nonzero remainder lands below the round bit as sticky.
    assign qv = {r_q[DIV_STEPS-1], 20'd0, (r_rem[DIV_STEPS-1] != 25'd0)};

    s3i_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_spec (r_spk[DIV_STEPS-1]),
        .i_p    (qv),
        .i_eb   (r_ebk[DIV_STEPS-1]),
        .o_word (o_word)
    );

endmodule
`default_nettype wire
